FILE: rtl/core/ule_pkg.sv
package ule_pkg;

  localparam int unsigned LINE_DEPTH_DEF = 128;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned BIT_TICKS_W  = 16;
  localparam int unsigned BIT_CNT_W    = 4;
  localparam int unsigned ERR_W        = 2;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BIT_TICKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_CHAR  = 1'd1;

  localparam logic [BIT_TICKS_W-1:0] BIT_TICKS_RST = 16'd104;
  localparam logic [BYTE_W-1:0]      END_CHAR_RST  = 8'h0D;

  // data bits per character, 8N1
  localparam logic [BIT_CNT_W-1:0] BITS_PER_CHAR = 4'd8;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_START = 4'b0010,
    PH_DATA  = 4'b0100,
    PH_STOP  = 4'b1000
  } phase_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE        = 2'd0,
    ERR_FALSE_START = 2'd1,
    ERR_FRAMING     = 2'd2,
    ERR_OVERFLOW    = 2'd3
  } err_e;

  // receiver events for one tick
  typedef struct packed {
    logic              done;         // byte with good stop bit
    logic              false_start;
    logic              framing;
    logic [BYTE_W-1:0] data;
  } rx_evt_t;

endpackage

FILE: rtl/core/ule_if.sv
interface ule_in_if;
  import ule_pkg::*;

  logic valid;
  logic ready;
  logic rx_level;

  modport source (output valid, output rx_level, input ready);
  modport sink   (input valid, input rx_level, output ready);
endinterface

interface ule_out_if;
  import ule_pkg::*;

  logic              valid;
  logic              ready;
  logic              tx_level;
  logic [BYTE_W-1:0] rx_byte;
  logic              byte_valid;
  logic [ERR_W-1:0]  error_code;
  logic              echo_busy;

  modport source (output valid, output tx_level, output rx_byte, output byte_valid,
                  output error_code, output echo_busy, input ready);
  modport sink   (input valid, input tx_level, input rx_byte, input byte_valid,
                  input error_code, input echo_busy, output ready);
endinterface

FILE: rtl/core/ule_rx.sv
module ule_rx (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_i,     // tick processed
  input  logic                             run_i,      // tick processed, no echo
  input  logic                             rx_level_i,
  input  logic [ule_pkg::BIT_TICKS_W-1:0]  bit_ticks_i,
  output ule_pkg::rx_evt_t                 evt_o
);
  import ule_pkg::*;

  phase_e                 ph_q, ph_d;
  logic [BIT_TICKS_W-1:0] cnt_q, cnt_d, cnt_inc, target;
  logic [BIT_CNT_W-1:0]   bit_q, bit_d, bit_inc;
  logic [BYTE_W-1:0]      shift_q, shift_d;
  logic                   last_q, last_d;
  logic                   hit;

  assign cnt_inc = cnt_q + 16'd1;
  assign bit_inc = bit_q + 4'd1;
  assign target  = (ph_q == PH_START) ? {1'b0, bit_ticks_i[BIT_TICKS_W-1:1]} : bit_ticks_i;
  assign hit     = (cnt_inc >= target);

  always_comb begin
    ph_d    = ph_q;
    cnt_d   = cnt_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    last_d  = step_i ? rx_level_i : last_q;
    evt_o   = '0;
    if (run_i) begin
      case (ph_q)
        PH_IDLE: begin
          if (last_q && !rx_level_i) begin
            ph_d  = PH_START;
            cnt_d = '0;
          end
        end
        PH_START: begin
          cnt_d = hit ? '0 : cnt_inc;
          if (hit) begin
            if (rx_level_i) begin
              evt_o.false_start = 1'b1;
              ph_d              = PH_IDLE;
            end else begin
              ph_d  = PH_DATA;
              bit_d = '0;
            end
          end
        end
        PH_DATA: begin
          cnt_d = hit ? '0 : cnt_inc;
          if (hit) begin
            shift_d = {rx_level_i, shift_q[BYTE_W-1:1]};
            bit_d   = bit_inc;
            if (bit_inc >= BITS_PER_CHAR) begin
              ph_d = PH_STOP;
            end
          end
        end
        PH_STOP: begin
          cnt_d = hit ? '0 : cnt_inc;
          if (hit) begin
            ph_d = PH_IDLE;
            if (rx_level_i) begin
              evt_o.done = 1'b1;
              evt_o.data = shift_q;
            end else begin
              evt_o.framing = 1'b1;
            end
          end
        end
        default: begin
          ph_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= PH_IDLE;
      cnt_q   <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      last_q  <= 1'b1;
    end else if (step_i) begin
      ph_q    <= ph_d;
      cnt_q   <= cnt_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      last_q  <= last_d;
    end
  end

endmodule

FILE: rtl/core/uart_line_echo.sv
// UART line echo. Each transfer on the input channel is one sampling tick of the
// receive line; each tick yields exactly one result transfer carrying the transmit
// line level for that tick plus receive status. An 8N1 receiver arms on a falling
// edge, checks the start bit at bit_ticks/2, then samples 8 data bits LSB first and
// the stop bit, one bit period (bit_ticks ticks) apart. Good bytes are appended to a
// LINE_DEPTH-byte line store; a byte arriving with the store full is reported as
// overflow and dropped. When the byte equal to end_char arrives, the stored line
// (without the terminator) is sent 8N1 on tx_level starting the next tick, and the
// receive line is ignored until the echo is done. One tick is taken per clock cycle
// while results are not stalled; a tick passes the input register, then the result
// register; the input register can still take a tick while a result is stalled.
// Config writes (bit_ticks at index 0, end_char at index 1) must only be issued while
// no tick is in flight. The line store has no reset; only written entries are used.
module uart_line_echo #(
  parameter int unsigned LINE_DEPTH = ule_pkg::LINE_DEPTH_DEF  // 2..255
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  ule_in_if.sink                          item_i,
  ule_out_if.source                       result_o,
  input  logic                            cfg_we_i,
  input  logic [ule_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ule_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import ule_pkg::*;

  localparam int unsigned LEN_W  = $clog2(LINE_DEPTH + 1);
  localparam int unsigned ADDR_W = $clog2(LINE_DEPTH);

  // config registers
  logic [BIT_TICKS_W-1:0] bit_ticks_q;
  logic [BYTE_W-1:0]      end_char_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_ticks_q <= BIT_TICKS_RST;
      end_char_q  <= END_CHAR_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_BIT_TICKS) begin
        bit_ticks_q <= cfg_wdata_i[BIT_TICKS_W-1:0];
      end
      if (cfg_idx_i == REG_END_CHAR) begin
        end_char_q <= cfg_wdata_i[BYTE_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: input register -> tick logic -> result register
  // ---------------------------------------------------------------------------
  logic s1_valid_q, s1_level_q;
  logic out_valid_q;
  logic adv, step;

  assign adv          = !out_valid_q || result_o.ready;
  assign step         = s1_valid_q && adv;
  assign item_i.ready = !s1_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (item_i.ready) begin
        s1_valid_q <= item_i.valid;
      end
      if (adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      s1_level_q <= item_i.rx_level;
    end
  end

  // ---------------------------------------------------------------------------
  // Transmitter state and line store
  // ---------------------------------------------------------------------------
  phase_e                 tx_ph_q, tx_ph_d, tk_ph;
  logic [BIT_TICKS_W-1:0] tx_cnt_q, tx_cnt_d, tk_cnt, tx_cnt_inc;
  logic [BIT_CNT_W-1:0]   tx_bit_q, tx_bit_d, tk_bit, tx_bit_inc;
  logic [LEN_W-1:0]       tx_idx_q, tx_idx_d, tk_idx, tx_idx_inc;
  logic [BYTE_W-1:0]      tx_shift_q, tx_shift_d, tk_shift;
  logic [LEN_W-1:0]       len_q, len_d, tk_len;
  logic                   tx_hit, tx_lvl;

  logic [BYTE_W-1:0]      mem [LINE_DEPTH];
  logic [BYTE_W-1:0]      rd_q;
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_wa;

  rx_evt_t                evt;
  logic                   rx_run;

  logic                   res_tx_level, res_byte_valid, res_busy;
  logic [BYTE_W-1:0]      res_rx_byte;
  err_e                   res_err;

  assign tx_cnt_inc = tx_cnt_q + 16'd1;
  assign tx_bit_inc = tx_bit_q + 4'd1;
  assign tx_idx_inc = tx_idx_q + LEN_W'(1);
  assign tx_hit     = (tx_cnt_inc >= bit_ticks_q);

  // One tick of the transmitter. The next byte's data comes from rd_q, which
  // always holds the store entry at the current read index.
  always_comb begin
    tk_ph    = tx_ph_q;
    tk_cnt   = tx_cnt_q;
    tk_bit   = tx_bit_q;
    tk_idx   = tx_idx_q;
    tk_shift = tx_shift_q;
    tk_len   = len_q;
    tx_lvl   = 1'b1;
    case (tx_ph_q)
      PH_IDLE: begin
        tx_lvl = 1'b1;
      end
      PH_START: begin
        tx_lvl = 1'b0;
        tk_cnt = tx_hit ? '0 : tx_cnt_inc;
        if (tx_hit) begin
          tk_ph    = PH_DATA;
          tk_bit   = '0;
          tk_shift = rd_q;
        end
      end
      PH_DATA: begin
        tx_lvl = tx_shift_q[0];
        tk_cnt = tx_hit ? '0 : tx_cnt_inc;
        if (tx_hit) begin
          tk_shift = {1'b0, tx_shift_q[BYTE_W-1:1]};
          tk_bit   = tx_bit_inc;
          if (tx_bit_inc >= BITS_PER_CHAR) begin
            tk_ph = PH_STOP;
          end
        end
      end
      PH_STOP: begin
        tx_lvl = 1'b1;
        tk_cnt = tx_hit ? '0 : tx_cnt_inc;
        if (tx_hit) begin
          if (tx_idx_inc < len_q) begin
            tk_idx = tx_idx_inc;
            tk_ph  = PH_START;
          end else begin
            // line done: store empties
            tk_ph  = PH_IDLE;
            tk_idx = '0;
            tk_len = '0;
          end
        end
      end
      default: begin
        tk_ph = PH_IDLE;
      end
    endcase
  end

  // receiver listens only when no echo runs after this tick's transmit step
  assign rx_run = step && (tk_ph == PH_IDLE);

  ule_rx u_rx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .run_i       (rx_run),
    .rx_level_i  (s1_level_q),
    .bit_ticks_i (bit_ticks_q),
    .evt_o       (evt)
  );

  // Apply the tick: transmitter first, then receiver events.
  always_comb begin
    tx_ph_d    = tx_ph_q;
    tx_cnt_d   = tx_cnt_q;
    tx_bit_d   = tx_bit_q;
    tx_idx_d   = tx_idx_q;
    tx_shift_d = tx_shift_q;
    len_d      = len_q;
    mem_we     = 1'b0;
    mem_wa     = tk_len[ADDR_W-1:0];
    res_err    = ERR_NONE;
    if (step) begin
      tx_ph_d    = tk_ph;
      tx_cnt_d   = tk_cnt;
      tx_bit_d   = tk_bit;
      tx_idx_d   = tk_idx;
      tx_shift_d = tk_shift;
      len_d      = tk_len;
    end
    if (evt.false_start) begin
      res_err = ERR_FALSE_START;
    end
    if (evt.framing) begin
      res_err = ERR_FRAMING;
    end
    if (evt.done) begin
      if (evt.data == end_char_q) begin
        // terminator: echo the line if there is one; byte 0 goes out first
        if (tk_len != '0) begin
          tx_ph_d  = PH_START;
          tx_idx_d = '0;
          tx_cnt_d = '0;
          tx_bit_d = '0;
        end
      end else if (tk_len >= LEN_W'(LINE_DEPTH)) begin
        res_err = ERR_OVERFLOW;
      end else begin
        mem_we = 1'b1;
        len_d  = tk_len + LEN_W'(1);
      end
    end
  end

  assign res_tx_level   = tx_lvl;
  assign res_byte_valid = evt.done;
  assign res_rx_byte    = evt.done ? evt.data : '0;
  assign res_busy       = (tx_ph_q != PH_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_ph_q  <= PH_IDLE;
      tx_cnt_q <= '0;
      tx_bit_q <= '0;
      tx_idx_q <= '0;
      len_q    <= '0;
    end else begin
      tx_ph_q  <= tx_ph_d;
      tx_cnt_q <= tx_cnt_d;
      tx_bit_q <= tx_bit_d;
      tx_idx_q <= tx_idx_d;
      len_q    <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tx_shift_q <= tx_shift_d;
  end

  // Line store: one write port (receiver), one registered read port that
  // tracks the next read index. Writes and echo reads never overlap.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= evt.data;
    end
    rd_q <= mem[tx_idx_d[ADDR_W-1:0]];
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic              out_tx_level_q, out_byte_valid_q, out_busy_q;
  logic [BYTE_W-1:0] out_rx_byte_q;
  logic [ERR_W-1:0]  out_err_q;

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_tx_level_q   <= res_tx_level;
      out_rx_byte_q    <= res_rx_byte;
      out_byte_valid_q <= res_byte_valid;
      out_err_q        <= res_err;
      out_busy_q       <= res_busy;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.tx_level   = out_tx_level_q;
  assign result_o.rx_byte    = out_rx_byte_q;
  assign result_o.byte_valid = out_byte_valid_q;
  assign result_o.error_code = out_err_q;
  assign result_o.echo_busy  = out_busy_q;

endmodule

FILE: tb/sv/uart_line_echo_tb.sv
`timescale 1ns / 100ps

module uart_line_echo_tb;
  import ule_pkg::*;

  localparam int unsigned LINE_DEPTH  = LINE_DEPTH_DEF;
  // generous: every tick paying the worst sender gap and sink stall, several times over
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned HOLD_CYCLES = 300;

  // one result transfer, field for field as on result_o
  typedef struct packed {
    logic              tx_level;
    logic [BYTE_W-1:0] rx_byte;
    logic              byte_valid;
    err_e              error_code;
    logic              echo_busy;
  } tick_out_t;

  // what to put on the receive line while the echo runs (it is ignored then)
  typedef enum logic [1:0] {
    FILL_HIGH,
    FILL_LOW,
    FILL_NOISE
  } echo_fill_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  ule_in_if  item_bus ();
  ule_out_if res_bus ();

  uart_line_echo dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_bus.sink),
    .result_o    (res_bus.source),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Line echo predictor: own copy of the receiver, line store and transmitter
  // ---------------------------------------------------------------------------
  logic [BIT_TICKS_W-1:0] bit_period = BIT_TICKS_RST;
  logic [BYTE_W-1:0]      eol_char   = END_CHAR_RST;

  phase_e                 rx_ph, tx_ph;
  logic [BIT_TICKS_W-1:0] rx_cnt, tx_cnt;
  logic [BIT_CNT_W-1:0]   rx_bits, tx_bits;
  logic [BYTE_W-1:0]      rx_sh, tx_sh;
  logic                   prev_lvl;
  logic [BYTE_W-1:0]      line_mem [LINE_DEPTH];
  logic [7:0]             line_len, tx_idx;

  task automatic reset_line_model();
    rx_ph    = PH_IDLE;
    tx_ph    = PH_IDLE;
    rx_cnt   = '0;
    tx_cnt   = '0;
    rx_bits  = '0;
    tx_bits  = '0;
    rx_sh    = '0;
    tx_sh    = '0;
    prev_lvl = 1'b1;
    line_len = '0;
    tx_idx   = '0;
  endtask

  // one sampling tick: transmitter first, then the receiver (only while no echo)
  task automatic line_echo_step(input logic lvl, output tick_out_t r);
    logic [BIT_TICKS_W-1:0] target;
    r = '0;
    r.error_code = ERR_NONE;
    r.echo_busy  = (tx_ph != PH_IDLE);
    r.tx_level   = 1'b1;
    if (tx_ph != PH_IDLE) begin
      case (tx_ph)
        PH_START: r.tx_level = 1'b0;
        PH_DATA:  r.tx_level = tx_sh[0];
        default:  r.tx_level = 1'b1;
      endcase
      tx_cnt = tx_cnt + 1'b1;
      if (tx_cnt >= bit_period) begin
        tx_cnt = '0;
        case (tx_ph)
          PH_START: begin
            tx_ph   = PH_DATA;
            tx_bits = '0;
          end
          PH_DATA: begin
            tx_sh   = tx_sh >> 1;
            tx_bits = tx_bits + 1'b1;
            if (tx_bits >= BITS_PER_CHAR) tx_ph = PH_STOP;
          end
          default: begin
            tx_idx = tx_idx + 1'b1;
            if (tx_idx < line_len) begin
              tx_sh = line_mem[tx_idx];
              tx_ph = PH_START;
            end else begin
              tx_ph    = PH_IDLE;
              tx_idx   = '0;
              line_len = '0;
            end
          end
        endcase
      end
    end

    if (tx_ph == PH_IDLE) begin
      if (rx_ph == PH_IDLE) begin
        if (prev_lvl && !lvl) begin
          rx_ph  = PH_START;
          rx_cnt = '0;
        end
      end else begin
        target = (rx_ph == PH_START) ? (bit_period >> 1) : bit_period;
        rx_cnt = rx_cnt + 1'b1;
        if (rx_cnt >= target) begin
          rx_cnt = '0;
          case (rx_ph)
            PH_START: begin
              if (lvl) begin
                r.error_code = ERR_FALSE_START;
                rx_ph = PH_IDLE;
              end else begin
                rx_ph   = PH_DATA;
                rx_bits = '0;
              end
            end
            PH_DATA: begin
              rx_sh   = {lvl, rx_sh[7:1]};
              rx_bits = rx_bits + 1'b1;
              if (rx_bits >= BITS_PER_CHAR) rx_ph = PH_STOP;
            end
            default: begin
              rx_ph = PH_IDLE;
              if (!lvl) begin
                r.error_code = ERR_FRAMING;
              end else begin
                r.rx_byte    = rx_sh;
                r.byte_valid = 1'b1;
                if (rx_sh == eol_char) begin
                  // empty line: terminator starts nothing
                  if (line_len != 0) begin
                    tx_idx  = '0;
                    tx_sh   = line_mem[0];
                    tx_ph   = PH_START;
                    tx_cnt  = '0;
                    tx_bits = '0;
                  end
                end else if (line_len >= LINE_DEPTH) begin
                  r.error_code = ERR_OVERFLOW;
                end else begin
                  line_mem[line_len] = rx_sh;
                  line_len = line_len + 1'b1;
                end
              end
            end
          endcase
        end
      end
    end
    prev_lvl = lvl;
  endtask

  // ---------------------------------------------------------------------------
  // Shared queues and flags
  // ---------------------------------------------------------------------------
  logic        rx_ticks_queued [$];   // line levels waiting to be driven
  tick_out_t   tick_results_due [$];  // predicted results, oldest first
  int unsigned sampled_ticks = 0;     // ticks queued outside of echo fill
  int unsigned fail_count    = 0;
  int unsigned cycle_count   = 0;
  bit          steady_tail   = 1'b0;  // no new random gaps on either side once set
  int unsigned hold_req      = 0;     // bumped by the sequence to ask for a long sink hold

  // ---------------------------------------------------------------------------
  // Driver: one tick per transfer; predictor runs on each accepted tick
  // ---------------------------------------------------------------------------
  int unsigned src_gap;
  tick_out_t   want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_bus.valid    <= 1'b0;
      item_bus.rx_level <= 1'b1;
      src_gap = 0;
      reset_line_model();
    end else begin
      if (item_bus.valid && item_bus.ready) begin
        line_echo_step(item_bus.rx_level, want);
        tick_results_due.push_back(want);
      end
      // hold the offered tick until it is taken
      if (!item_bus.valid || item_bus.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          item_bus.valid <= 1'b0;
        end else if (!steady_tail && $urandom_range(15, 0) == 0) begin
          src_gap = $urandom_range(7, 0);  // random burst of idle cycles
          item_bus.valid <= 1'b0;
        end else if (rx_ticks_queued.size() != 0) begin
          item_bus.valid    <= 1'b1;
          item_bus.rx_level <= rx_ticks_queued.pop_front();
        end else begin
          item_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks every result transfer against the oldest prediction
  // ---------------------------------------------------------------------------
  int unsigned sink_stall, sink_hold, hold_ack;
  tick_out_t   got, due;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
      sink_stall = 0;
      sink_hold  = 0;
      hold_ack   = 0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        got.tx_level   = res_bus.tx_level;
        got.rx_byte    = res_bus.rx_byte;
        got.byte_valid = res_bus.byte_valid;
        got.error_code = err_e'(res_bus.error_code);
        got.echo_busy  = res_bus.echo_busy;
        if (tick_results_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("cycle %0d: result transfer with no tick outstanding", cycle_count);
        end else begin
          due = tick_results_due.pop_front();
          if (got.tx_level !== due.tx_level || got.rx_byte !== due.rx_byte ||
              got.byte_valid !== due.byte_valid || got.error_code !== due.error_code ||
              got.echo_busy !== due.echo_busy) begin
            fail_count++;
            if (fail_count <= 10)
              $display("cyc %0d exp/got tx %b/%b byte %h/%h vld %b/%b err %0d/%0d busy %b/%b",
                       cycle_count,
                       due.tx_level, got.tx_level, due.rx_byte, got.rx_byte,
                       due.byte_valid, got.byte_valid, due.error_code, got.error_code,
                       due.echo_busy, got.echo_busy);
          end
        end
      end
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        sink_hold = HOLD_CYCLES;
      end
      if (sink_hold > 0) begin
        sink_hold--;
        res_bus.ready <= 1'b0;
      end else if (sink_stall > 0) begin
        sink_stall--;
        res_bus.ready <= 1'b0;
      end else if (!steady_tail && $urandom_range(15, 0) == 0) begin
        sink_stall = $urandom_range(7, 0);
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int unsigned bit_w();
    return (bit_period == 0) ? 1 : bit_period;
  endfunction

  task automatic push_level(input logic lvl, input int unsigned n);
    repeat (n) begin
      rx_ticks_queued.push_back(lvl);
      sampled_ticks++;
    end
  endtask

  // 8N1 character, each bit held one bit period; low stop bit gives a framing error
  task automatic push_frame(input logic [7:0] b, input logic stop_lvl);
    int unsigned w;
    w = bit_w();
    // below two ticks per bit the start check lands on the tick after the edge
    push_level(1'b0, (bit_period <= 1) ? w + 1 : w);
    for (int k = 0; k < 8; k++) push_level(b[k], w);
    push_level(stop_lvl, w);
    if (!stop_lvl) push_level(1'b1, w);
  endtask

  // all queued ticks driven and taken by the block
  task automatic wait_ticks_taken();
    do @(negedge clk_i); while (rx_ticks_queued.size() != 0 || item_bus.valid);
  endtask

  // keep ticking while the predicted echo runs; chunks stay short of its end
  task automatic ride_out_echo(input echo_fill_e fill);
    int unsigned rem, left;
    logic        lvl;
    wait_ticks_taken();
    while (tx_ph != PH_IDLE) begin
      rem  = line_len - tx_idx;
      left = (rem > 1) ? (rem - 1) * 10 * bit_w() : bit_w();
      repeat (left) begin
        case (fill)
          FILL_LOW:   lvl = 1'b0;
          FILL_NOISE: lvl = (rem > 1) ? 1'($urandom_range(1, 0)) : 1'b1;
          default:    lvl = 1'b1;
        endcase
        rx_ticks_queued.push_back(lvl);
      end
      wait_ticks_taken();
    end
  endtask

  // block idle: no echo, every result in, pipeline flushed
  task automatic drain_and_settle();
    ride_out_echo(FILL_HIGH);
    while (tick_results_due.size() != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_BIT_TICKS) bit_period = val;
    else eol_char = val[BYTE_W-1:0];
  endtask

  // one random line: mostly good frames, some errors and noise, usually terminated
  task automatic random_line();
    int unsigned n, w, h, pick;
    logic [7:0]  b;
    w = bit_w();
    h = bit_period >> 1;
    n = ($urandom_range(7, 0) == 0) ? $urandom_range(24, 9) : $urandom_range(6, 0);
    for (int i = 0; i < n; i++) begin
      b = $urandom_range(255, 0);
      if (b == eol_char) b = b ^ 8'h01;
      pick = $urandom_range(19, 0);
      if (pick == 0) begin
        push_frame(b, 1'b0);
      end else if (pick == 1) begin
        // short glitch, line back high before the start check
        push_level(1'b0, (h <= 1) ? 1 : $urandom_range(h - 1, 1));
        push_level(1'b1, w);
        push_frame(b, 1'b1);
      end else if (pick == 2) begin
        repeat ($urandom_range(3 * w, 1)) push_level(1'($urandom_range(1, 0)), 1);
        push_level(1'b1, 10 * w + 2);
      end else begin
        push_frame(b, 1'b1);
      end
      push_level(1'b1, $urandom_range(2 * w, 0));
    end
    if ($urandom_range(9, 0) != 0) push_frame(eol_char, 1'b1);
    ride_out_echo(echo_fill_e'($urandom_range(2, 0)));
    push_level(1'b1, 2);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned random_goal, lines;
    logic [7:0]  b;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = REG_BIT_TICKS;
    cfg_wdata_i       = '0;
    item_bus.valid    = 1'b0;
    item_bus.rx_level = 1'b1;
    res_bus.ready     = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // short bit period, default terminator
    write_reg(REG_BIT_TICKS, 16'd4);
    write_reg(REG_END_CHAR, 16'h000D);
    push_level(1'b1, 6);
    push_frame(8'h00, 1'b1);
    push_frame(8'hFF, 1'b1);
    push_frame(8'h5A, 1'b1);
    push_frame(8'h0D, 1'b1);
    ride_out_echo(FILL_NOISE);
    push_level(1'b1, 4);
    push_frame(8'h0D, 1'b1);       // empty line, no echo
    push_level(1'b0, 1);           // false start
    push_level(1'b1, 6);
    push_frame(8'hA5, 1'b0);       // framing error
    // line held low across the end of the echo: no edge until it goes high again
    push_frame(8'h78, 1'b1);
    push_frame(8'h0D, 1'b1);
    ride_out_echo(FILL_LOW);
    push_level(1'b0, 5);
    push_level(1'b1, 6);
    push_frame(8'h31, 1'b1);
    push_frame(8'h0D, 1'b1);

    // terminator at zero
    drain_and_settle();
    write_reg(REG_END_CHAR, 16'h0000);
    write_reg(REG_BIT_TICKS, 16'd2);
    push_frame(8'hFF, 1'b1);
    push_frame(8'h80, 1'b1);
    push_frame(8'h01, 1'b1);
    push_frame(8'h00, 1'b1);
    ride_out_echo(FILL_NOISE);
    push_level(1'b1, 2);

    // bit periods below the usual range, terminator at all ones
    drain_and_settle();
    write_reg(REG_END_CHAR, 16'h00FF);
    write_reg(REG_BIT_TICKS, 16'd1);
    push_frame(8'h12, 1'b1);
    push_frame(8'hFF, 1'b1);
    ride_out_echo(FILL_HIGH);
    push_level(1'b1, 4);
    drain_and_settle();
    write_reg(REG_BIT_TICKS, 16'd0);
    push_frame(8'h34, 1'b1);
    push_frame(8'hFF, 1'b1);
    ride_out_echo(FILL_HIGH);
    repeat (20) push_level(1'($urandom_range(1, 0)), 1);
    push_level(1'b1, 12);

    // fill the line store past its depth; long sink hold while ticks keep coming
    drain_and_settle();
    write_reg(REG_BIT_TICKS, 16'd1);
    write_reg(REG_END_CHAR, 16'h000D);
    for (int i = 0; i < LINE_DEPTH + 2; i++) begin
      b = $urandom_range(255, 0);
      if (b == 8'h0D) b = 8'h0C;
      push_frame(b, 1'b1);
    end
    push_frame(8'h0D, 1'b1);
    @(negedge clk_i);
    hold_req++;
    ride_out_echo(FILL_HIGH);

    // random lines; settings change between groups with the block idle
    random_goal = sampled_ticks + 300;
    lines = 0;
    while (sampled_ticks < random_goal) begin
      if (lines % 4 == 0) begin
        drain_and_settle();
        write_reg(REG_BIT_TICKS, ($urandom_range(4, 0) == 0) ?
                  16'($urandom_range(40, 9)) : 16'($urandom_range(8, 2)));
        if ($urandom_range(1, 0) == 1) write_reg(REG_END_CHAR, 16'($urandom_range(255, 0)));
        push_level(1'b1, 2);
      end
      if (sampled_ticks + 120 >= random_goal) steady_tail = 1'b1;
      random_line();
      lines++;
    end

    wait_ticks_taken();
    while (tick_results_due.size() != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
